@@ rtl/core/nlrd_pkg.sv @@
// Shared types and constants for the note loop recorder/detector.
// Holds the channel words, the stored event entry and the sequencer states.
// No dependencies.
package nlrd_pkg;

  localparam int NOTE_W  = 7;
  localparam int VEL_W   = 7;
  localparam int CHAN_W  = 4;
  localparam int TS_W    = 32;
  localparam int DELTA_W = 16;
  localparam int CODE_W  = 3;
  localparam int LEN_W   = 6;
  localparam int POS_W   = 5;
  localparam int SLOT_W  = 2;
  localparam int WIN_W   = 8;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHORD_WIN = 1'b1;

  localparam logic [WIN_W-1:0]   CHORD_WIN_RST = 8'd10;
  localparam logic [DELTA_W-1:0] DELTA_MAX     = 16'hFFFF;
  localparam int                 MIN_SEARCH    = 5;

  typedef enum logic [CODE_W-1:0] {
    RES_PASS    = 3'd0,
    RES_IGNORED = 3'd1,
    RES_RECORD  = 3'd2,
    RES_LOOP    = 3'd3,
    RES_FULL    = 3'd4,
    RES_START   = 3'd5
  } res_code_t;

  typedef enum logic [SLOT_W-1:0] {
    SLOT_IDLE   = 2'd0,
    SLOT_PLAY   = 2'd1,
    SLOT_RECORD = 2'd2
  } slot_t;

  typedef struct packed {
    logic              action;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  velocity;
    logic [CHAN_W-1:0] channel;
    logic [TS_W-1:0]   timestamp;
  } in_word_t;

  typedef struct packed {
    logic [CODE_W-1:0] result_code;
    logic [LEN_W-1:0]  loop_length;
    logic [POS_W-1:0]  loop_position;
    logic [SLOT_W-1:0] slot_state;
    logic [CHAN_W-1:0] slot_channel;
  } out_word_t;

  // vel[7] is the chord flag, vel[6:0] the halved velocity
  typedef struct packed {
    logic [DELTA_W-1:0] delta;
    logic [NOTE_W-1:0]  note;
    logic [7:0]         vel;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_REC_RD,
    S_REC_CHK,
    S_REC_W2,
    S_SORT_INIT,
    S_SORT_LD,
    S_SORT_RD,
    S_SORT_CMP,
    S_SORT_TAIL,
    S_SRCH_PREP,
    S_INIT,
    S_INIT_CHK,
    S_RD,
    S_CHK,
    S_PREV,
    S_PREV_CHK,
    S_NEXT,
    S_DONE
  } fsm_t;

  function automatic logic is_off(entry_t e);
    return e.vel[6:0] == 7'd0;
  endfunction

endpackage

@@ rtl/core/note_loop_recorder_detector.sv @@
// Note loop recorder/detector for one slot: event store, chord sort, loop search.
// Depends on nlrd_pkg. Event store is a 2-read/1-write synchronous memory.
// Sequence: start/pass/ignore/full words go straight to the result; a recorded note is
//   read, then written, plus a sort by note in passes when a chord is formed (c = stored
//   events, at most c passes), plus a loop search over each tried start.
// Flow: one word in flight; no new word is taken until the current result is loaded,
//   set by the single memory sequencer. A finished result may wait while the next word
//   is accepted. Reset clears control state and the configuration registers; the store
//   contents are undefined until written, no clearing pass.
module note_loop_recorder_detector #(
  parameter int EVENT_DEPTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [nlrd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nlrd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  nlrd_pkg::in_word_t                  in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output nlrd_pkg::out_word_t                 out_word
);
  import nlrd_pkg::*;

  localparam int AW = $clog2(EVENT_DEPTH);
  localparam int CW = $clog2(EVENT_DEPTH + 1);

  // store and read ports
  entry_t mem [EVENT_DEPTH];
  entry_t qa, qb;
  logic            we;
  logic [AW-1:0]   wa, rb;
  entry_t          wd;

  // control and state registers
  fsm_t            state, state_next;
  logic            auto_mode;
  logic [WIN_W-1:0] chord_win;
  logic [CW-1:0]   event_count, loop_size, st, bi, common;
  logic [CHAN_W-1:0] record_channel;
  logic [TS_W-1:0] last_event_time;
  slot_t           rstate;
  res_code_t       code;
  logic [CW-1:0]   pos;
  in_word_t        item;
  logic [DELTA_W-1:0] dlt;
  logic [AW-1:0]   ai, wi;
  entry_t          carry;
  logic            swapped;

  logic            accept, chord, sw_hit, run_hit;
  logic [TS_W-1:0] diff;
  logic [CW-1:0]   cnt_m1;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign diff   = item.timestamp - last_event_time;
  assign cnt_m1 = event_count - CW'(1);

  assign chord = (event_count != '0) && ({8'd0, chord_win} > dlt) && (qb.note != item.note);
  assign sw_hit = (carry.delta == qa.delta) && (carry.note > qa.note);
  assign run_hit = (qa.note == qb.note) && (qa.vel[7] == qb.vel[7]);

  // memory: one write, two registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    qa <= mem[ai];
    qb <= mem[rb];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_word.action && rstate == SLOT_RECORD && event_count < CW'(EVENT_DEPTH) &&
              !(in_word.velocity == '0 && event_count == '0)) begin
            state_next = S_REC_RD;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_REC_RD:    state_next = S_REC_CHK;
      S_REC_CHK:   state_next = chord ? S_REC_W2 : S_SRCH_PREP;
      S_REC_W2:    state_next = S_SORT_INIT;
      S_SORT_INIT: state_next = S_SORT_LD;
      S_SORT_LD:   state_next = S_SORT_RD;
      S_SORT_RD:   state_next = S_SORT_CMP;
      S_SORT_CMP:  state_next = (CW'(wi) == event_count - CW'(2)) ? S_SORT_TAIL : S_SORT_RD;
      S_SORT_TAIL: state_next = swapped ? S_SORT_INIT : S_SRCH_PREP;
      S_SRCH_PREP: begin
        if (item.velocity != '0 && event_count >= CW'(MIN_SEARCH)) begin
          state_next = S_INIT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_INIT: state_next = S_INIT_CHK;
      S_INIT_CHK: begin
        if (is_off(qa) || is_off(qb) || !run_hit) begin
          state_next = S_NEXT;
        end else begin
          state_next = S_CHK;
        end
      end
      S_RD: state_next = (bi >= event_count) ? S_NEXT : S_CHK;
      S_CHK: begin
        if (CW'(ai) < bi && is_off(qa)) begin
          state_next = S_RD;
        end else if (CW'(ai) == bi) begin
          state_next = S_NEXT;
        end else if (is_off(qb)) begin
          state_next = S_RD;
        end else if (run_hit) begin
          state_next = (ai == '0) ? S_RD : S_PREV;
        end else begin
          state_next = S_NEXT;
        end
      end
      S_PREV:     state_next = S_PREV_CHK;
      S_PREV_CHK: state_next = S_RD;
      S_NEXT: begin
        if (common >= CW'(2) || st <= CW'(2)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_INIT;
        end
      end
      S_DONE: state_next = (!out_valid || !out_stall) ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory port controls
  always_comb begin
    we = 1'b0;
    wa = bi[AW-1:0];
    wd = carry;
    rb = bi[AW-1:0];
    case (state)
      S_REC_CHK: begin
        we = 1'b1;
        wa = event_count[AW-1:0];
        wd.delta = chord ? qb.delta : dlt;
        wd.note  = item.note;
        wd.vel   = {chord, 1'b0, item.velocity[VEL_W-1:1]};
      end
      S_REC_W2: begin
        we = 1'b1;
        wa = bi[AW-1:0];
        wd = qb;
        wd.vel[7] = 1'b1;
      end
      S_SORT_CMP: begin
        we = 1'b1;
        wa = wi;
        wd = sw_hit ? qa : carry;
      end
      S_SORT_TAIL: begin
        we = 1'b1;
        wa = cnt_m1[AW-1:0];
        wd = carry;
      end
      S_PREV: rb = ai - AW'(1);
      default: ;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      auto_mode       <= 1'b1;
      chord_win       <= CHORD_WIN_RST;
      event_count     <= '0;
      loop_size       <= '0;
      record_channel  <= '0;
      last_event_time <= '0;
      rstate          <= SLOT_IDLE;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_AUTO_MODE: auto_mode <= cfg_data[0];
          CFG_CHORD_WIN: chord_win <= cfg_data;
          default: ;
        endcase
      end
      // S_DONE reloads the output register itself
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            item <= in_word;
            pos  <= '0;
            bi   <= cnt_m1;
            if (!in_word.action) begin
              event_count    <= '0;
              loop_size      <= '0;
              record_channel <= '0;
              rstate         <= SLOT_RECORD;
              code           <= RES_START;
            end else if (rstate != SLOT_RECORD) begin
              code <= RES_PASS;
            end else if (event_count >= CW'(EVENT_DEPTH)) begin
              event_count    <= '0;
              loop_size      <= '0;
              record_channel <= '0;
              rstate         <= SLOT_IDLE;
              code           <= RES_FULL;
            end else if (in_word.velocity == '0 && event_count == '0) begin
              code <= RES_IGNORED;
            end else begin
              code <= RES_RECORD;
              if (event_count == '0) begin
                record_channel <= in_word.channel;
              end
            end
          end
        end
        S_REC_RD: begin
          last_event_time <= item.timestamp;
          if (event_count == '0) begin
            dlt <= '0;
          end else if (diff > TS_W'(DELTA_MAX)) begin
            dlt <= DELTA_MAX;
          end else begin
            dlt <= diff[DELTA_W-1:0];
          end
        end
        S_REC_CHK: event_count <= event_count + CW'(1);
        S_REC_W2, S_SORT_TAIL: begin
          ai      <= '0;
          swapped <= 1'b0;
        end
        S_SORT_LD: begin
          carry <= qa;
          ai    <= AW'(1);
          wi    <= '0;
        end
        S_SORT_CMP: begin
          if (sw_hit) begin
            swapped <= 1'b1;
          end else begin
            carry <= qa;
          end
          wi <= wi + AW'(1);
          ai <= ai + AW'(1);
        end
        S_SRCH_PREP: begin
          st     <= event_count - CW'(3);
          bi     <= event_count - CW'(3);
          ai     <= '0;
          common <= '0;
        end
        S_CHK: begin
          if (CW'(ai) < bi && is_off(qa)) begin
            ai <= ai + AW'(1);
          end else if (CW'(ai) != bi) begin
            if (is_off(qb)) begin
              bi <= bi + CW'(1);
            end else if (run_hit && ai == '0) begin
              common <= common + CW'(1);
              ai     <= ai + AW'(1);
              bi     <= bi + CW'(1);
            end
          end
        end
        S_PREV_CHK: begin
          // qa still holds entry a, qb holds entry a-1
          if (qa.delta != qb.delta) begin
            common <= common + CW'(1);
          end
          ai <= ai + AW'(1);
          bi <= bi + CW'(1);
        end
        S_NEXT: begin
          if (common >= CW'(2)) begin
            loop_size <= st + CW'(1);
            pos       <= event_count - (st + CW'(1));
            code      <= RES_LOOP;
            if (auto_mode) begin
              rstate <= SLOT_PLAY;
            end
          end else begin
            st     <= st - CW'(1);
            bi     <= st - CW'(1);
            ai     <= '0;
            common <= '0;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid              <= 1'b1;
            out_word.result_code   <= code;
            out_word.loop_length   <= LEN_W'(loop_size);
            out_word.loop_position <= POS_W'(pos);
            out_word.slot_state    <= rstate;
            out_word.slot_channel  <= record_channel;
          end
        end
        default: ;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    event_count <= CW'(EVENT_DEPTH))
    else $error("event count beyond depth");

  a_loop_fits: assert property (@(posedge clk) disable iff (rst)
    loop_size == '0 || loop_size + CW'(2) <= event_count)
    else $error("loop size exceeds recorded events");

  a_walk_order: assert property (@(posedge clk) disable iff (rst)
    state == S_CHK |-> CW'(ai) <= bi)
    else $error("run compare pointers crossed");

  a_loop_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.result_code == RES_LOOP |-> out_word.loop_length != '0)
    else $error("loop reported without length");

endmodule

@@ verif/note_loop_recorder_detector_tb.sv @@
// Self-checking bench for the note loop recorder/detector: random and directed note words,
// predicted results kept in a scoreboard and compared in order on the result channel.
// Depends on nlrd_pkg and the note_loop_recorder_detector RTL.
module note_loop_recorder_detector_tb;
  import nlrd_pkg::*;

  localparam int DEPTH = 32;

  class loop_scoreboard;
    entry_t store [DEPTH+1];
    int unsigned count, loop_len, chan, last_ts, slot;
    bit auto_on;
    int unsigned win;
    out_word_t pending[$];
    int errors;
    int loops_seen, fulls_seen;

    function void reset_model();
      clear();
      last_ts = 0;
      slot = SLOT_IDLE;
      auto_on = 1;
      win = CHORD_WIN_RST;
    endfunction

    function void clear();
      for (int i = 0; i <= DEPTH; i++) store[i] = '0;
      count = 0;
      loop_len = 0;
      chan = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      if (idx == CFG_AUTO_MODE) auto_on = v[0];
      else win = v;
    endfunction

    function bit off_at(int unsigned i);
      return store[i].vel[6:0] == 7'd0;
    endfunction

    function bit runs_agree(int unsigned a, int unsigned b);
      int unsigned common;
      common = 0;
      if (off_at(a) || off_at(b) || store[a].vel[7] != store[b].vel[7] ||
          store[a].note != store[b].note) return 0;
      while (b < count) begin
        while (a < b && off_at(a)) a++;
        if (a == b) break;
        while (b < count && off_at(b)) b++;
        if (b == count) break;
        if (store[a].note == store[b].note && store[a].vel[7] == store[b].vel[7]) begin
          if (a == 0 || store[a].delta != store[a-1].delta) common++;
        end else break;
        a++;
        b++;
      end
      return common >= 2;
    endfunction

    function void sort_by_note();
      bit swapped;
      entry_t t;
      swapped = 1;
      while (swapped) begin
        swapped = 0;
        // scan reaches the newest entry, as the block does
        for (int unsigned i = 0; i < count; i++) begin
          if (store[i].delta == store[i+1].delta && store[i].note > store[i+1].note) begin
            t = store[i];
            store[i] = store[i+1];
            store[i+1] = t;
            swapped = 1;
          end
        end
      end
    endfunction

    function void note_input(in_word_t w);
      out_word_t r;
      int unsigned n, d, pos, st;
      res_code_t code;
      pos = 0;
      if (w.action == 1'b0) begin
        clear();
        slot = SLOT_RECORD;
        code = RES_START;
      end else if (slot != SLOT_RECORD) begin
        code = RES_PASS;
      end else if (count >= DEPTH) begin
        clear();
        slot = SLOT_IDLE;
        code = RES_FULL;
      end else if (w.velocity == 0 && count == 0) begin
        code = RES_IGNORED;
      end else begin
        n = count;
        d = 0;
        if (n == 0) chan = w.channel;
        else begin
          d = w.timestamp - last_ts;
          if (d > 32'hFFFF) d = 32'hFFFF;
        end
        store[n].note = w.note;
        store[n].vel = {2'b00, w.velocity[6:1]};
        store[n].delta = d[15:0];
        last_ts = w.timestamp;
        // chord: close in time to a different note
        if (n > 0 && d < win && store[n-1].note != store[n].note) begin
          store[n].delta = store[n-1].delta;
          store[n].vel[7] = 1'b1;
          store[n-1].vel[7] = 1'b1;
          sort_by_note();
        end
        count = n + 1;
        code = RES_RECORD;
        if (w.velocity != 0 && count >= MIN_SEARCH) begin
          st = count - 3;
          while (st > 1) begin
            if (runs_agree(0, st)) begin
              loop_len = st + 1;
              pos = count - loop_len;
              code = RES_LOOP;
              if (auto_on) slot = SLOT_PLAY;
              break;
            end
            st--;
          end
        end
      end
      if (code == RES_LOOP) loops_seen++;
      if (code == RES_FULL) fulls_seen++;
      r.result_code = code;
      r.loop_length = loop_len[5:0];
      r.loop_position = pos[4:0];
      r.slot_state = slot[1:0];
      r.slot_channel = chan[3:0];
      pending.push_back(r);
    endfunction

    function void check_result(out_word_t got);
      out_word_t e;
      if (pending.size() == 0) begin
        $error("result word with nothing expected: %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.result_code !== e.result_code) begin
        $error("result_code exp %0d got %0d", e.result_code, got.result_code); errors++;
      end
      if (got.loop_length !== e.loop_length) begin
        $error("loop_length exp %0d got %0d", e.loop_length, got.loop_length); errors++;
      end
      if (got.loop_position !== e.loop_position) begin
        $error("loop_position exp %0d got %0d", e.loop_position, got.loop_position);
        errors++;
      end
      if (got.slot_state !== e.slot_state) begin
        $error("slot_state exp %0d got %0d", e.slot_state, got.slot_state); errors++;
      end
      if (got.slot_channel !== e.slot_channel) begin
        $error("slot_channel exp %0d got %0d", e.slot_channel, got.slot_channel); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  in_word_t in_word = '0;
  out_word_t out_word;

  loop_scoreboard sb;
  int unsigned now_ms = 0;
  int unsigned sent_total = 0;
  int hold_cycles = 0;
  bit hold_req = 0;
  bit receiver_on = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  note_loop_recorder_detector #(.EVENT_DEPTH(DEPTH)) dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_word, .out_valid, .out_stall, .out_word
  );

  // receiver: own stall pattern, plus one long hold-off on request
  always @(posedge clk) begin
    if (out_valid && !out_stall && !rst) sb.check_result(out_word);
    if (hold_req && hold_cycles < 3000) begin
      hold_cycles <= hold_cycles + 1;
      out_stall <= 1;
    end else if (!receiver_on) out_stall <= 0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  // valid stays up after acceptance; idle() or drain() drops it
  task automatic send_word(in_word_t w);
    in_valid <= 1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(w);
    sent_total++;
  endtask

  task automatic idle(int unsigned n);
    if (n == 0) return;
    in_valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  function automatic in_word_t make_note(int unsigned nt, int unsigned vel, int unsigned gap);
    in_word_t w;
    now_ms += gap;
    w.action = 1;
    w.note = nt[6:0];
    w.velocity = vel[6:0];
    w.channel = 4'($urandom_range(0, 15));
    w.timestamp = now_ms;
    return w;
  endfunction

  function automatic in_word_t start_word();
    in_word_t w;
    w = make_note(0, 0, 0);
    w.action = 0;
    w.note = 7'($urandom);
    w.velocity = 7'($urandom);
    w.timestamp = $urandom;
    return w;
  endfunction

  function automatic int unsigned rand_gap();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 12);
      1: return $urandom_range(65536, 200000);
      default: return $urandom_range(20, 600);
    endcase
  endfunction

  // a repeated phrase with random content: the way loops get found
  task automatic send_phrase();
    int unsigned notes [8];
    int unsigned gaps [8];
    int unsigned plen, reps, burst;
    plen = $urandom_range(2, 6);
    reps = $urandom_range(2, 4);
    for (int i = 0; i < plen; i++) begin
      notes[i] = $urandom_range(0, 127);
      gaps[i] = rand_gap();
    end
    send_word(start_word());
    burst = $urandom_range(1, 8);
    for (int r = 0; r < reps; r++)
      for (int i = 0; i < plen; i++) begin
        if ($urandom_range(0, 19) == 0) send_word(make_note($urandom, $urandom, rand_gap()));
        else send_word(make_note(notes[i], $urandom_range(1, 127), gaps[i]));
        if (--burst == 0) begin
          idle($urandom_range(0, 6));
          burst = $urandom_range(1, 8);
        end
      end
  endtask

  initial begin
    #200_000_000;
    $display("[note_loop_recorder_detector] ERROR");
    $finish;
  end

  initial begin
    sb = new();
    sb.reset_model();
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: pass through, ignored lead off, extremes, chords, full store
    write_reg(CFG_CHORD_WIN, 8'd10);
    send_word(make_note(127, 127, 5));
    send_word(start_word());
    send_word(make_note(60, 0, 3));
    send_word(make_note(0, 127, 3));
    send_word(make_note(127, 1, 4));
    send_word(make_note(64, 0, 100));
    send_word(make_note(70, 127, 70000));
    send_word(make_note(65, 90, 2));
    send_word(make_note(65, 90, 2));
    for (int i = 0; i < 26; i++) send_word(make_note(i * 5, 1, 300));
    send_word(make_note(1, 2, 3));
    send_word(make_note(1, 2, 3));
    now_ms = 32'hFFFF_FFF0;
    send_word(start_word());
    send_word(make_note(10, 100, 0));
    send_word(make_note(20, 100, 40));
    drain();

    write_reg(CFG_AUTO_MODE, 8'd0);
    write_reg(CFG_CHORD_WIN, 8'd0);
    receiver_on = 1;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        1: begin write_reg(CFG_CHORD_WIN, 8'd255); write_reg(CFG_AUTO_MODE, 8'd1); end
        2: write_reg(CFG_CHORD_WIN, 8'($urandom_range(1, 40)));
        3: begin write_reg(CFG_CHORD_WIN, 8'd10); write_reg(CFG_AUTO_MODE, 8'($urandom)); end
        default: ;
      endcase
      while (sent_total < 40 + (ph + 1) * 135) begin
        if (ph == 2 && !hold_req && sent_total >= 340) hold_req = 1;
        if ($urandom_range(0, 5) != 0) send_phrase();
        else send_word(make_note($urandom, $urandom, rand_gap()));
      end
      drain();
    end

    $display("covered: %0d words, %0d loop finds, %0d full-store resets, chord windows 0..255",
             sent_total, sb.loops_seen, sb.fulls_seen);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[note_loop_recorder_detector] OK");
    else
      $display("[note_loop_recorder_detector] ERROR");
    $finish;
  end
endmodule
